[hw/rtl/scsa_pkg.sv]
package scsa_pkg;

  localparam int SIZE_W     = 16;
  localparam int ADDR_IN_W  = 24;
  localparam int SLOT_IN_W  = ADDR_IN_W - 4;
  localparam int RES_ADDR_W = 20;
  localparam int CLS_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int LIMIT_W    = 5;
  localparam int SPAN_IDX_W = 8;
  localparam int OBJ_W      = 13;

  localparam logic [STATUS_W-1:0] ST_ALLOCATED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREED      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_ARENA  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UNTAGGED   = 3'd5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_ERR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic [STATUS_W-1:0]       status;
    logic [CLS_W-1:0]          cls;
    logic [SLOT_IN_W-1:0]      slot;
    logic [SPAN_IDX_W-1:0]     span;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [RES_ADDR_W-1:0] addr;
    logic [CLS_W-1:0]      cls;
  } res_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_CARVE
  } bk_state_t;

  function automatic logic [OBJ_W-1:0] class_bytes(input logic [CLS_W-1:0] c);
    logic [OBJ_W-1:0] b;
    unique case (c)
      4'd0:  b = 13'd16;
      4'd1:  b = 13'd32;
      4'd2:  b = 13'd48;
      4'd3:  b = 13'd64;
      4'd4:  b = 13'd96;
      4'd5:  b = 13'd128;
      4'd6:  b = 13'd192;
      4'd7:  b = 13'd256;
      4'd8:  b = 13'd384;
      4'd9:  b = 13'd512;
      4'd10: b = 13'd768;
      4'd11: b = 13'd1024;
      4'd12: b = 13'd1536;
      4'd13: b = 13'd2048;
      4'd14: b = 13'd3072;
      4'd15: b = 13'd4096;
      default: b = 13'd4096;
    endcase
    return b;
  endfunction

endpackage

[hw/rtl/scsa_fifo.sv]
module scsa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

[hw/rtl/scsa_front.sv]
module scsa_front #(
  parameter int MAX_REQUEST = 4096,
  parameter int NUM_CLASSES = 16,
  parameter int ARENA_BYTES = 1048576,
  parameter int SPAN_SHIFT  = 16
) (
  input  logic                           operation,
  input  logic [scsa_pkg::SIZE_W-1:0]    request_size,
  input  logic [scsa_pkg::ADDR_IN_W-1:0] address,
  output scsa_pkg::cmd_t                 cmd
);

  logic [scsa_pkg::SIZE_W:0]    rounded;
  logic                         found;
  logic [scsa_pkg::CLS_W-1:0]   cls;
  logic                         too_large;
  logic                         out_arena;

  always_comb begin
    rounded = ({1'b0, request_size} + 17'd15) & ~17'd15;
    found   = 1'b0;
    cls     = '0;
    for (int c = 0; c < 16; c++) begin
      if (!found && c < NUM_CLASSES &&
          17'(scsa_pkg::class_bytes(4'(c))) >= rounded) begin
        found = 1'b1;
        cls   = 4'(c);
      end
    end
    too_large = (32'(request_size) > 32'(MAX_REQUEST)) || !found;
    out_arena = (32'(address) >= 32'(ARENA_BYTES));

    cmd.slot = address[scsa_pkg::ADDR_IN_W-1:4];
    cmd.span = scsa_pkg::SPAN_IDX_W'(address >> SPAN_SHIFT);
    cmd.cls  = cls;
    if (operation == scsa_pkg::OP_ALLOC) begin
      cmd.kind   = too_large ? scsa_pkg::CMD_ERR : scsa_pkg::CMD_ALLOC;
      cmd.status = scsa_pkg::ST_TOO_LARGE;
    end else begin
      cmd.kind   = out_arena ? scsa_pkg::CMD_ERR : scsa_pkg::CMD_FREE;
      cmd.status = scsa_pkg::ST_NOT_ARENA;
    end
  end

endmodule

[hw/rtl/scsa_back.sv]
module scsa_back #(
  parameter int ARENA_SPANS  = 16,
  parameter int SPAN_BYTES   = 65536,
  parameter int HEADER_BYTES = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [scsa_pkg::LIMIT_W-1:0] span_limit,
  input  scsa_pkg::cmd_t               cmd,
  input  logic                         cmd_empty,
  output logic                         cmd_pop,
  input  logic                         res_full,
  output logic                         res_push,
  output scsa_pkg::res_t               res
);

  localparam int ARENA_BYTES = ARENA_SPANS * SPAN_BYTES;
  localparam int ADDR_W      = $clog2(ARENA_BYTES) + 1;
  localparam int ARENA_SLOTS = ARENA_BYTES / 16;
  localparam int SLOT_W      = $clog2(ARENA_SLOTS);
  localparam int LINK_W      = $clog2(ARENA_SLOTS + 1);
  localparam int USED_W      = $clog2(ARENA_SPANS + 1);
  localparam int SI_W        = (ARENA_SPANS > 1) ? $clog2(ARENA_SPANS) : 1;
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(ARENA_SLOTS);

  scsa_pkg::bk_state_t state_r, state_nxt;

  logic [LINK_W-1:0]          heads_r [16];
  logic                       tag_v_r [ARENA_SPANS];
  logic [scsa_pkg::CLS_W-1:0] tag_cls_r [ARENA_SPANS];
  logic [USED_W-1:0]          used_r;

  logic [LINK_W-1:0] link_mem [ARENA_SLOTS];
  logic [LINK_W-1:0] rdata_r;

  logic [scsa_pkg::CLS_W-1:0]  cls_r, cls_nxt;
  logic [LINK_W-1:0]           head_r, head_nxt;
  logic [LINK_W-1:0]           acc_r, acc_nxt;
  logic [ADDR_W-1:0]           p_r, p_nxt;
  logic [ADDR_W-1:0]           first_r, first_nxt;
  logic [scsa_pkg::OBJ_W-1:0]  objsz_r, objsz_nxt;

  logic                        head_we;
  logic [scsa_pkg::CLS_W-1:0]  head_wcls;
  logic [LINK_W-1:0]           head_wdata;
  logic                        carve_start;
  logic                        mem_we, mem_re;
  logic [SLOT_W-1:0]           mem_waddr, mem_raddr;
  logic [LINK_W-1:0]           mem_wdata;

  logic [LINK_W-1:0]           cur_head;
  logic [SI_W-1:0]             span_idx;
  logic [SI_W-1:0]             used_idx;
  logic [ADDR_W-1:0]           base;
  logic [scsa_pkg::OBJ_W-1:0]  cmd_obj;

  always_comb begin
    cur_head   = heads_r[cmd.cls];
    span_idx   = SI_W'(cmd.span);
    used_idx   = SI_W'(used_r);
    base       = ADDR_W'(used_r) * ADDR_W'(SPAN_BYTES);
    cmd_obj    = scsa_pkg::class_bytes(cmd.cls);

    state_nxt   = state_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res         = '0;
    head_we     = 1'b0;
    head_wcls   = cmd.cls;
    head_wdata  = acc_r;
    carve_start = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = SLOT_W'(cmd.slot);
    mem_wdata   = cur_head;
    mem_re      = 1'b0;
    mem_raddr   = SLOT_W'(cur_head);
    cls_nxt     = cls_r;
    head_nxt    = head_r;
    acc_nxt     = acc_r;
    p_nxt       = p_r;
    first_nxt   = first_r;
    objsz_nxt   = objsz_r;

    unique case (state_r)
      scsa_pkg::BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          unique case (cmd.kind)
            scsa_pkg::CMD_ALLOC: begin
              cls_nxt = cmd.cls;
              if (32'(cur_head) < 32'(ARENA_SLOTS)) begin
                mem_re    = 1'b1;
                head_nxt  = cur_head;
                state_nxt = scsa_pkg::BK_POP;
              end else if (32'(used_r) < 32'(span_limit) &&
                           32'(used_r) < 32'(ARENA_SPANS)) begin
                carve_start = 1'b1;
                objsz_nxt   = cmd_obj;
                first_nxt   = base + ADDR_W'(HEADER_BYTES);
                p_nxt       = base + ADDR_W'(SPAN_BYTES) - ADDR_W'(cmd_obj);
                acc_nxt     = NULL_LINK;
                state_nxt   = scsa_pkg::BK_CARVE;
              end else begin
                res_push   = 1'b1;
                res.status = scsa_pkg::ST_NO_MEMORY;
              end
            end
            scsa_pkg::CMD_FREE: begin
              res_push = 1'b1;
              if (!tag_v_r[span_idx]) begin
                res.status = scsa_pkg::ST_UNTAGGED;
              end else begin
                head_wcls  = tag_cls_r[span_idx];
                mem_wdata  = heads_r[tag_cls_r[span_idx]];
                mem_we     = 1'b1;
                head_we    = 1'b1;
                head_wdata = LINK_W'(cmd.slot);
                res.status = scsa_pkg::ST_FREED;
                res.addr   = {cmd.slot[scsa_pkg::RES_ADDR_W-5:0], 4'd0};
                res.cls    = tag_cls_r[span_idx];
              end
            end
            default: begin
              res_push   = 1'b1;
              res.status = cmd.status;
            end
          endcase
        end
      end
      scsa_pkg::BK_POP: begin
        head_we    = 1'b1;
        head_wcls  = cls_r;
        head_wdata = rdata_r;
        res_push   = 1'b1;
        res.status = scsa_pkg::ST_ALLOCATED;
        res.addr   = scsa_pkg::RES_ADDR_W'({head_r, 4'd0});
        res.cls    = cls_r;
        state_nxt  = scsa_pkg::BK_IDLE;
      end
      scsa_pkg::BK_CARVE: begin
        if (p_r >= first_r + ADDR_W'(objsz_r)) begin
          mem_we    = 1'b1;
          mem_waddr = SLOT_W'(p_r >> 4);
          mem_wdata = acc_r;
          acc_nxt   = LINK_W'(p_r >> 4);
          p_nxt     = p_r - ADDR_W'(objsz_r);
        end else begin
          head_we    = 1'b1;
          head_wcls  = cls_r;
          head_wdata = acc_r;
          res_push   = 1'b1;
          res.status = scsa_pkg::ST_ALLOCATED;
          res.addr   = scsa_pkg::RES_ADDR_W'(first_r);
          res.cls    = cls_r;
          state_nxt  = scsa_pkg::BK_IDLE;
        end
      end
      default: state_nxt = scsa_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scsa_pkg::BK_IDLE;
      used_r  <= '0;
      for (int i = 0; i < 16; i++) begin
        heads_r[i] <= NULL_LINK;
      end
      for (int i = 0; i < ARENA_SPANS; i++) begin
        tag_v_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (head_we) begin
        heads_r[head_wcls] <= head_wdata;
      end
      if (carve_start) begin
        tag_v_r[used_idx] <= 1'b1;
        used_r            <= used_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cls_r   <= cls_nxt;
    head_r  <= head_nxt;
    acc_r   <= acc_nxt;
    p_r     <= p_nxt;
    first_r <= first_nxt;
    objsz_r <= objsz_nxt;
    if (carve_start) begin
      tag_cls_r[used_idx] <= cmd.cls;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= link_mem[mem_raddr];
    end
  end

endmodule

[hw/rtl/size_class_slab_allocator_top.sv]
// Slab allocator with 16 size classes over an arena of carved spans.
// Input queue: in_push/in_full; a word carries in_operation (0 allocate,
// 1 free), in_request_size and in_address. Result queue: out_empty/out_pop;
// the oldest result sits on out_status, out_result_address, out_size_class
// while out_empty is low. Configuration: cfg_valid/cfg_ready with
// cfg_span_limit, the number of spans that may be carved; write it only
// while no request is in flight.
// A request is classified on entry, queued, then executed. A free, an
// error, or an allocate that misses its free list while no span may be
// carved finishes in the executor's idle state; an allocate from a free
// list also passes through the pop state (link memory read). An allocate
// that carves a new span walks the span once, one object per cycle, which
// sets the worst case. The executor takes a new request only after the last
// one is finished and while the result queue has room.
// Reset empties both queues, all free lists and span tags and sets
// span_limit to 16; link memory is not cleared. When the receiver stalls,
// results wait in a two-word queue, requests keep entering a two-word queue
// until it fills, then in_full rises.
module size_class_slab_allocator_top #(
  parameter int ARENA_SPANS  = 16,
  parameter int SPAN_BYTES   = 65536,
  parameter int HEADER_BYTES = 64,
  parameter int MAX_REQUEST  = 4096,
  parameter int NUM_CLASSES  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic                              in_operation,
  input  logic [scsa_pkg::SIZE_W-1:0]       in_request_size,
  input  logic [scsa_pkg::ADDR_IN_W-1:0]    in_address,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [scsa_pkg::STATUS_W-1:0]     out_status,
  output logic [scsa_pkg::RES_ADDR_W-1:0]   out_result_address,
  output logic [scsa_pkg::CLS_W-1:0]        out_size_class,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scsa_pkg::LIMIT_W-1:0]      cfg_span_limit
);

  localparam int ARENA_BYTES = ARENA_SPANS * SPAN_BYTES;
  localparam int SPAN_SHIFT  = $clog2(SPAN_BYTES);

  logic [scsa_pkg::LIMIT_W-1:0] span_limit_r;
  scsa_pkg::cmd_t cmd_in, cmd_out;
  logic           cmd_empty, cmd_pop;
  scsa_pkg::res_t res_in, res_out;
  logic           res_full, res_push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_limit_r <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      span_limit_r <= cfg_span_limit;
    end
  end

  scsa_front #(
    .MAX_REQUEST (MAX_REQUEST),
    .NUM_CLASSES (NUM_CLASSES),
    .ARENA_BYTES (ARENA_BYTES),
    .SPAN_SHIFT  (SPAN_SHIFT)
  ) u_front (
    .operation    (in_operation),
    .request_size (in_request_size),
    .address      (in_address),
    .cmd          (cmd_in)
  );

  scsa_fifo #(
    .W     ($bits(scsa_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  scsa_back #(
    .ARENA_SPANS  (ARENA_SPANS),
    .SPAN_BYTES   (SPAN_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .span_limit (span_limit_r),
    .cmd        (cmd_out),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  scsa_fifo #(
    .W     ($bits(scsa_pkg::res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_out),
    .empty (out_empty)
  );

  assign out_status         = res_out.status;
  assign out_result_address = res_out.addr;
  assign out_size_class     = res_out.cls;

endmodule

[dv/size_class_slab_allocator_top_tb.sv]
`timescale 1ns / 100ps

module size_class_slab_allocator_top_tb;

  localparam int ARENA_SPANS  = 16;
  localparam int SPAN_BYTES   = 65536;
  localparam int HEADER_BYTES = 64;
  localparam int MAX_REQUEST  = 4096;
  localparam int ARENA_BYTES  = ARENA_SPANS * SPAN_BYTES;
  localparam int ARENA_SLOTS  = ARENA_BYTES / 16;
  localparam int NULL_SLOT    = ARENA_SLOTS;
  localparam int CYCLE_LIMIT  = 2000000;

  typedef struct {
    logic [scsa_pkg::STATUS_W-1:0]   status;
    logic [scsa_pkg::RES_ADDR_W-1:0] addr;
    logic [scsa_pkg::CLS_W-1:0]      cls;
  } outcome_t;

  class slab_scoreboard;
    int       heads[16];
    int       links[int];
    int       tags[ARENA_SPANS];
    int       spans_used;
    int       limit;
    int       live[$];
    outcome_t pending[$];
    int       errors;

    function new();
      foreach (heads[i]) heads[i] = NULL_SLOT;
      foreach (tags[i]) tags[i] = 0;
      spans_used = 0;
      limit = 16;
      errors = 0;
    endfunction

    function int obj_bytes(int c);
      int sz[16] = '{16, 32, 48, 64, 96, 128, 192, 256,
                     384, 512, 768, 1024, 1536, 2048, 3072, 4096};
      return sz[c];
    endfunction

    function int pick_class(int size);
      int rounded;
      if (size > MAX_REQUEST) return -1;
      rounded = (size + 15) & ~15;
      for (int c = 0; c < 16; c++)
        if (obj_bytes(c) >= rounded) return c;
      return -1;
    endfunction

    function int carve_span(int c);
      int base, objsz, first, p, head;
      base = spans_used * SPAN_BYTES;
      objsz = obj_bytes(c);
      first = base + HEADER_BYTES;
      p = base + SPAN_BYTES - objsz;
      head = NULL_SLOT;
      tags[spans_used] = 16 | c;
      spans_used++;
      while (p >= first + objsz) begin
        links[p >> 4] = head;
        head = p >> 4;
        p -= objsz;
      end
      heads[c] = head;
      return first;
    endfunction

    function void note_request(bit op, int size, int addr);
      outcome_t o;
      int c, cap, tag, slot;
      o.status = scsa_pkg::ST_ALLOCATED;
      o.addr = '0;
      o.cls = '0;
      if (op == scsa_pkg::OP_ALLOC) begin
        c = pick_class(size);
        cap = (limit < ARENA_SPANS) ? limit : ARENA_SPANS;
        if (c < 0) begin
          o.status = scsa_pkg::ST_TOO_LARGE;
        end else if (heads[c] < ARENA_SLOTS) begin
          o.addr = heads[c] << 4;
          o.cls = c;
          heads[c] = links[heads[c]];
          live.push_back(o.addr);
        end else if (spans_used < cap) begin
          o.addr = carve_span(c);
          o.cls = c;
          live.push_back(o.addr);
        end else begin
          o.status = scsa_pkg::ST_NO_MEMORY;
        end
      end else begin
        tag = (addr < ARENA_BYTES) ? tags[addr / SPAN_BYTES] : 0;
        if (addr >= ARENA_BYTES) begin
          o.status = scsa_pkg::ST_NOT_ARENA;
        end else if (!tag[4]) begin
          o.status = scsa_pkg::ST_UNTAGGED;
        end else begin
          slot = addr >> 4;
          links[slot] = heads[tag & 15];
          heads[tag & 15] = slot;
          o.status = scsa_pkg::ST_FREED;
          o.addr = slot << 4;
          o.cls = tag & 15;
        end
      end
      pending.push_back(o);
    endfunction

    function void check_result(logic [scsa_pkg::STATUS_W-1:0] st,
                               logic [scsa_pkg::RES_ADDR_W-1:0] a,
                               logic [scsa_pkg::CLS_W-1:0] c);
      outcome_t o;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word status=%0d addr=%h class=%0d", $time, st, a, c);
        errors++;
        return;
      end
      o = pending.pop_front();
      if (st !== o.status) begin
        $display("%0t: status expected %0d actual %0d", $time, o.status, st);
        errors++;
      end
      if (a !== o.addr) begin
        $display("%0t: address expected %h actual %h", $time, o.addr, a);
        errors++;
      end
      if (c !== o.cls) begin
        $display("%0t: class expected %0d actual %0d", $time, o.cls, c);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_push;
  logic                            in_full;
  logic                            in_operation;
  logic [scsa_pkg::SIZE_W-1:0]     in_request_size;
  logic [scsa_pkg::ADDR_IN_W-1:0]  in_address;
  logic                            out_empty;
  logic                            out_pop;
  logic [scsa_pkg::STATUS_W-1:0]   out_status;
  logic [scsa_pkg::RES_ADDR_W-1:0] out_result_address;
  logic [scsa_pkg::CLS_W-1:0]      out_size_class;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [scsa_pkg::LIMIT_W-1:0]    cfg_span_limit;

  slab_scoreboard sb;
  int  cycles;
  int  hold_request;
  bit  steady;

  size_class_slab_allocator_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_full(in_full),
    .in_operation(in_operation),
    .in_request_size(in_request_size),
    .in_address(in_address),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_status(out_status),
    .out_result_address(out_result_address),
    .out_size_class(out_size_class),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_span_limit(cfg_span_limit)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int stall;
    stall = 0;
    out_pop = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_pop && !out_empty)
        sb.check_result(out_status, out_result_address, out_size_class);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
        if (!steady && $urandom_range(99) < 35)
          stall = ($urandom_range(99) < 8) ? $urandom_range(80, 20) : $urandom_range(3, 1);
      end
      @(posedge clk);
    end
  end

  task automatic send_word(bit op, int size, int addr);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 30)
      gap = ($urandom_range(99) < 8) ? $urandom_range(60, 15) : $urandom_range(3, 1);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_operation <= op;
    in_request_size <= size[scsa_pkg::SIZE_W-1:0];
    in_address <= addr[scsa_pkg::ADDR_IN_W-1:0];
    do @(posedge clk); while (in_full);
    sb.note_request(op, size[scsa_pkg::SIZE_W-1:0], addr[scsa_pkg::ADDR_IN_W-1:0]);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_span_limit <= v[scsa_pkg::LIMIT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    sb.limit = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_words(int count);
    int k, r, a, idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (n % 150 == 40) hold_request = 300;
      if (n % 200 == 0) steady = !steady;
      if (r < 50) begin
        k = $urandom_range(99);
        if (k < 70) send_word(scsa_pkg::OP_ALLOC, 1'b0 + $urandom_range(256), 0);
        else if (k < 92) send_word(scsa_pkg::OP_ALLOC, $urandom_range(MAX_REQUEST), 0);
        else send_word(scsa_pkg::OP_ALLOC, $urandom_range(65535), 0);
      end else if (r < 85 && sb.live.size() > 0) begin
        idx = $urandom_range(sb.live.size() - 1);
        a = sb.live[idx];
        sb.live.delete(idx);
        send_word(scsa_pkg::OP_FREE, $urandom_range(65535), a);
      end else begin
        k = $urandom_range(99);
        if (k < 30) a = $urandom_range(24'hFFFFFF);
        else if (k < 55) a = $urandom_range(ARENA_BYTES - 1);
        else if (k < 75) a = ($urandom_range(ARENA_SPANS - 1) * SPAN_BYTES)
                             + $urandom_range(HEADER_BYTES - 1);
        else if (sb.live.size() > 0) a = sb.live[$urandom_range(sb.live.size() - 1)]
                                         + $urandom_range(15);
        else a = $urandom_range(ARENA_BYTES - 1);
        send_word(scsa_pkg::OP_FREE, $urandom_range(65535), a);
      end
    end
  endtask

  initial begin
    sb = new();
    cycles = 0;
    hold_request = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_operation = 1'b0;
    in_request_size = '0;
    in_address = '0;
    cfg_valid = 1'b0;
    cfg_span_limit = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_limit(1);
    send_word(scsa_pkg::OP_ALLOC, 0, 0);
    send_word(scsa_pkg::OP_ALLOC, 17, 0);
    send_word(scsa_pkg::OP_ALLOC, 4097, 0);
    send_word(scsa_pkg::OP_ALLOC, 65535, 0);
    send_word(scsa_pkg::OP_ALLOC, 4096, 0);
    send_word(scsa_pkg::OP_FREE, 0, 24'hFFFFFF);
    send_word(scsa_pkg::OP_FREE, 0, ARENA_BYTES);
    send_word(scsa_pkg::OP_FREE, 0, 5 * SPAN_BYTES + 32);
    send_word(scsa_pkg::OP_FREE, 0, HEADER_BYTES + 5);
    send_word(scsa_pkg::OP_FREE, 0, 16);
    send_word(scsa_pkg::OP_ALLOC, 16, 0);
    send_word(scsa_pkg::OP_ALLOC, 1, 0);
    send_word(scsa_pkg::OP_FREE, 0, 96);
    send_word(scsa_pkg::OP_FREE, 0, 96);
    send_word(scsa_pkg::OP_ALLOC, 8, 0);
    send_word(scsa_pkg::OP_ALLOC, 8, 0);
    write_limit(0);
    send_word(scsa_pkg::OP_ALLOC, 16, 0);
    send_word(scsa_pkg::OP_ALLOC, 32, 0);
    write_limit(31);
    send_word(scsa_pkg::OP_ALLOC, 4096, 0);
    send_word(scsa_pkg::OP_ALLOC, 3000, 0);
    random_words(400);
    write_limit(5);
    random_words(400);
    write_limit(16);
    random_words(480);
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
